@@ design/rbst_pkg.sv @@
// shared types and constants for the ray box slab test
`timescale 1ns / 1ps
`default_nettype none
package rbst_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DIR_W = 18;
	localparam int DIR_FRAC = 16;
	localparam int THR_W = 17;
	localparam int COORD_W = 32;
	localparam int DIST_W = 31;
	localparam int MAG_W = 18;
	localparam int RECIP_W = 49;
	localparam int DELTA_W = 34;
	localparam int PRODUCT_W = 83;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam logic [DIST_W-1:0] T_SAT = {DIST_W{1'b1}};

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X = 3'd3,
		REG_DIR_Y = 3'd4,
		REG_DIR_Z = 3'd5,
		REG_THRESHOLD = 3'd6,
		REG_NONE = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic par;
		logic neg;
		logic [RECIP_W-1:0] recip;
	} axis_t;

	typedef struct packed {
		logic busy;
		logic done;
	} recip_status_t;

endpackage
`default_nettype wire

@@ design/rbst_if.sv @@
// valid/ready channel interfaces for boxes and results
`timescale 1ns / 1ps
`default_nettype none
interface rbst_box_if;
	logic valid;
	logic ready;
	logic signed [rbst_pkg::COORD_W-1:0] box_min_x;
	logic signed [rbst_pkg::COORD_W-1:0] box_min_y;
	logic signed [rbst_pkg::COORD_W-1:0] box_min_z;
	logic signed [rbst_pkg::COORD_W-1:0] box_max_x;
	logic signed [rbst_pkg::COORD_W-1:0] box_max_y;
	logic signed [rbst_pkg::COORD_W-1:0] box_max_z;
	logic last_box;
	modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, last_box, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, last_box, output ready);
endinterface

interface rbst_res_if;
	logic valid;
	logic ready;
	logic hit;
	logic [rbst_pkg::DIST_W-1:0] entry_distance;
	logic last_result;
	modport source (output valid, hit, entry_distance, last_result, input ready);
	modport sink (input valid, hit, entry_distance, last_result, output ready);
endinterface
`default_nettype wire

@@ design/rbst_recip.sv @@
// sequential restoring divider for per-axis reciprocals, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rbst_recip (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rbst_pkg::MAG_W-1:0] divisor,
	output logic [rbst_pkg::RECIP_W-1:0] quotient,
	output rbst_pkg::recip_status_t status
);
	localparam int STEPS = 32 + rbst_pkg::DIR_FRAC + 1;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [rbst_pkg::MAG_W:0] rem_q;
	logic [rbst_pkg::MAG_W-1:0] div_q;
	logic [rbst_pkg::RECIP_W-1:0] quo_q;
	logic busy_q, done_q;
	logic [rbst_pkg::MAG_W:0] shifted;
	logic ge;

	// dividend is a single one at bit 48, fed in msb first
	assign shifted = {rem_q[rbst_pkg::MAG_W-1:0], (cnt_q == CNT_W'(STEPS))};
	assign ge = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? shifted - {1'b0, div_q} : shifted;
			quo_q <= {quo_q[rbst_pkg::RECIP_W-2:0], ge};
		end
	end

	assign quotient = (div_q == '0) ? '0 : quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;
endmodule
`default_nettype wire

@@ design/rbst_cfg.sv @@
// apb register file and derived per-axis reciprocal and parallel state
`timescale 1ns / 1ps
`default_nettype none
module rbst_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [rbst_pkg::PADDR_W-1:0] paddr,
	input wire logic [rbst_pkg::PDATA_W-1:0] pwdata,
	output logic [rbst_pkg::PDATA_W-1:0] prdata,
	output logic signed [rbst_pkg::COORD_W-1:0] origin [3],
	output rbst_pkg::axis_t axis [3],
	output logic busy
);
	logic signed [rbst_pkg::COORD_W-1:0] origin_q [3];
	logic signed [rbst_pkg::DIR_W-1:0] dir_q [3];
	logic [rbst_pkg::THR_W-1:0] thr_q;
	logic [rbst_pkg::RECIP_W-1:0] recip_q [3];
	logic [2:0] pend_q;
	logic [1:0] ax_q;
	logic div_start;
	logic div_q_busy;
	logic [rbst_pkg::MAG_W-1:0] mag [3];
	logic [rbst_pkg::RECIP_W-1:0] quo;
	rbst_pkg::recip_status_t st;
	rbst_pkg::reg_idx_t idx;
	logic wr;

	assign wr = psel && penable && pwrite;
	assign idx = rbst_pkg::reg_idx_t'(paddr[4:2]);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = dir_q[i][rbst_pkg::DIR_W-1]
				? rbst_pkg::MAG_W'(-dir_q[i]) : rbst_pkg::MAG_W'(dir_q[i]);
		end
	end

	// only reset or a direction change needs a new reciprocal, one axis at a time
	assign div_start = !st.busy && !st.done && !div_q_busy && pend_q != '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '{default: '0};
			dir_q[0] <= rbst_pkg::DIR_W'(65536);
			dir_q[1] <= '0;
			dir_q[2] <= '0;
			thr_q <= '0;
			pend_q <= 3'b111;
			ax_q <= '0;
			div_q_busy <= 1'b0;
			recip_q <= '{default: '0};
		end else begin
			if (wr) begin
				case (idx)
					rbst_pkg::REG_ORIGIN_X, rbst_pkg::REG_ORIGIN_Y,
					rbst_pkg::REG_ORIGIN_Z: origin_q[idx[1:0]] <= pwdata;
					rbst_pkg::REG_DIR_X, rbst_pkg::REG_DIR_Y, rbst_pkg::REG_DIR_Z: begin
						dir_q[2'(idx - rbst_pkg::REG_DIR_X)] <= pwdata[rbst_pkg::DIR_W-1:0];
					end
					rbst_pkg::REG_THRESHOLD: thr_q <= pwdata[rbst_pkg::THR_W-1:0];
					default: ;
				endcase
			end
			if (div_start) begin
				div_q_busy <= 1'b1;
				if (pend_q[0]) ax_q <= 2'd0;
				else if (pend_q[1]) ax_q <= 2'd1;
				else ax_q <= 2'd2;
			end
			if (st.done) begin
				recip_q[ax_q] <= quo;
				div_q_busy <= 1'b0;
			end
			begin
				logic [2:0] clr, setm;
				clr = '0;
				setm = '0;
				if (div_start) begin
					if (pend_q[0]) clr[0] = 1'b1;
					else if (pend_q[1]) clr[1] = 1'b1;
					else clr[2] = 1'b1;
				end
				if (wr && (idx == rbst_pkg::REG_DIR_X || idx == rbst_pkg::REG_DIR_Y
					|| idx == rbst_pkg::REG_DIR_Z)) begin
					setm[2'(idx - rbst_pkg::REG_DIR_X)] = 1'b1;
				end
				pend_q <= (pend_q & ~clr) | setm;
			end
		end
	end

	rbst_recip u_recip (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.divisor(pend_q[0] ? mag[0] : (pend_q[1] ? mag[1] : mag[2])),
		.quotient(quo),
		.status(st)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			origin[i] = origin_q[i];
			axis[i].par = mag[i] <= rbst_pkg::MAG_W'(thr_q);
			axis[i].neg = dir_q[i][rbst_pkg::DIR_W-1];
			axis[i].recip = recip_q[i];
		end
	end
	assign busy = div_q_busy || pend_q != '0;

	always_comb begin
		case (idx)
			rbst_pkg::REG_ORIGIN_X, rbst_pkg::REG_ORIGIN_Y,
			rbst_pkg::REG_ORIGIN_Z: prdata = origin_q[idx[1:0]];
			rbst_pkg::REG_DIR_X, rbst_pkg::REG_DIR_Y, rbst_pkg::REG_DIR_Z:
				prdata = rbst_pkg::PDATA_W'(signed'(dir_q[2'(idx - rbst_pkg::REG_DIR_X)]));
			rbst_pkg::REG_THRESHOLD: prdata = rbst_pkg::PDATA_W'(thr_q);
			default: prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

@@ design/rbst_axis.sv @@
// one axis slab: delta, split multiply, scaled distance, near/far order
`timescale 1ns / 1ps
`default_nettype none
module rbst_axis (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [rbst_pkg::COORD_W-1:0] lo,
	input wire logic signed [rbst_pkg::COORD_W-1:0] hi,
	input wire logic signed [rbst_pkg::COORD_W-1:0] origin,
	input rbst_pkg::axis_t ax,
	output logic signed [rbst_pkg::COORD_W:0] near_d,
	output logic signed [rbst_pkg::COORD_W:0] far_d,
	output logic out_miss
);
	localparam int DW = rbst_pkg::COORD_W + 1;
	localparam int RH = rbst_pkg::RECIP_W - 32;

	// stage 1: deltas and magnitudes
	logic [DW-1:0] mlo_s1, mhi_s1;
	logic nlo_s1, nhi_s1, par_s1, pmiss_s1;
	logic [rbst_pkg::RECIP_W-1:0] rc_s1;
	logic signed [DW-1:0] dlo, dhi;
	assign dlo = DW'(lo) - DW'(origin);
	assign dhi = DW'(hi) - DW'(origin);
	always_ff @(posedge clk) begin
		if (en) begin
			mlo_s1 <= dlo[DW-1] ? DW'(-dlo) : DW'(dlo);
			mhi_s1 <= dhi[DW-1] ? DW'(-dhi) : DW'(dhi);
			nlo_s1 <= dlo[DW-1] != ax.neg;
			nhi_s1 <= dhi[DW-1] != ax.neg;
			par_s1 <= ax.par;
			pmiss_s1 <= (origin < lo) || (origin > hi);
			rc_s1 <= ax.recip;
		end
	end

	// stage 2: partial products, 33x32 and 33x17 per bound
	logic [64:0] plo_l_s2, phi_l_s2;
	logic [DW+RH-1:0] plo_h_s2, phi_h_s2;
	logic nlo_s2, nhi_s2, par_s2, pmiss_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			plo_l_s2 <= 65'(mlo_s1) * 65'(rc_s1[31:0]);
			phi_l_s2 <= 65'(mhi_s1) * 65'(rc_s1[31:0]);
			plo_h_s2 <= (DW+RH)'(mlo_s1) * (DW+RH)'(rc_s1[rbst_pkg::RECIP_W-1:32]);
			phi_h_s2 <= (DW+RH)'(mhi_s1) * (DW+RH)'(rc_s1[rbst_pkg::RECIP_W-1:32]);
			nlo_s2 <= nlo_s1;
			nhi_s2 <= nhi_s1;
			par_s2 <= par_s1;
			pmiss_s2 <= pmiss_s1;
		end
	end

	// stage 3: combine, saturate, apply sign
	logic [DW+RH:0] qlo, qhi;
	logic signed [DW-1:0] slo, shi;
	assign qlo = (DW+RH+1)'(plo_h_s2) + (DW+RH+1)'(plo_l_s2[64:32]);
	assign qhi = (DW+RH+1)'(phi_h_s2) + (DW+RH+1)'(phi_l_s2[64:32]);
	always_comb begin
		logic [rbst_pkg::DIST_W-1:0] a, b;
		a = (qlo > (DW+RH+1)'(rbst_pkg::T_SAT)) ? rbst_pkg::T_SAT : qlo[rbst_pkg::DIST_W-1:0];
		b = (qhi > (DW+RH+1)'(rbst_pkg::T_SAT)) ? rbst_pkg::T_SAT : qhi[rbst_pkg::DIST_W-1:0];
		slo = nlo_s2 ? -signed'(DW'(a)) : signed'(DW'(a));
		shi = nhi_s2 ? -signed'(DW'(b)) : signed'(DW'(b));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			// a parallel axis leaves entry at zero and exit at max
			near_d <= par_s2 ? '0 : ((slo < shi) ? slo : shi);
			far_d <= par_s2 ? signed'(DW'(rbst_pkg::T_SAT)) : ((slo < shi) ? shi : slo);
			out_miss <= par_s2 && pmiss_s2;
		end
	end
endmodule
`default_nettype wire

@@ design/ray_box_slab_test.sv @@
// top level: ray against axis-aligned box, slab method, pipelined
//
//  channel  dir  handshake     payload
//  box      in   valid/ready   box_min_xyz, box_max_xyz, last_box
//  res      out  valid/ready   hit, entry_distance, last_result
//  apb      in   psel/penable  paddr, pwdata -> prdata
//
// one box per cycle unless stalled or rebuilding reciprocals
// the three axis multiply pipelines set the stage count: delta, split
// multiply, combine, then reduce and output register (four stages)
// a stall freezes every stage together; valid bits travel along
// after reset or a direction write, boxes wait while the shared
// bit-serial divider builds a reciprocal for each changed axis
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test (
	input wire logic clk,
	input wire logic arst_n,
	rbst_box_if.sink box,
	rbst_res_if.source res,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [rbst_pkg::PADDR_W-1:0] paddr,
	input wire logic [rbst_pkg::PDATA_W-1:0] pwdata,
	output logic [rbst_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	localparam int DW = rbst_pkg::COORD_W + 1;
	localparam int NST = 4;

	logic signed [rbst_pkg::COORD_W-1:0] origin [3];
	rbst_pkg::axis_t axis [3];
	logic cfg_busy;
	logic en;
	logic [NST-1:0] vld_q;
	logic [NST-2:0] last_q;
	logic signed [DW-1:0] near_d [3], far_d [3];
	logic [2:0] miss;
	logic signed [rbst_pkg::COORD_W-1:0] lo [3], hi [3];

	// register writes complete in the access cycle
	assign pready = 1'b1;

	rbst_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .origin(origin),
		.axis(axis), .busy(cfg_busy)
	);

	// whole pipe advances unless the output register is full and held
	assign en = !(vld_q[NST-1] && !res.ready);
	assign box.ready = en && !cfg_busy;

	assign lo[0] = box.box_min_x;
	assign lo[1] = box.box_min_y;
	assign lo[2] = box.box_min_z;
	assign hi[0] = box.box_max_x;
	assign hi[1] = box.box_max_y;
	assign hi[2] = box.box_max_z;

	for (genvar g = 0; g < 3; g++) begin : g_axis
		rbst_axis u_axis (
			.clk(clk), .en(en), .lo(lo[g]), .hi(hi[g]), .origin(origin[g]),
			.ax(axis[g]), .near_d(near_d[g]), .far_d(far_d[g]), .out_miss(miss[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], box.valid && box.ready};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[NST-3:0], box.last_box};
		end
	end

	// reduce: entry is max of near clamped at zero, exit min of far
	logic signed [DW-1:0] tmin, tmax;
	logic hit_c;
	always_comb begin
		tmin = '0;
		tmax = signed'(DW'(rbst_pkg::T_SAT));
		for (int i = 0; i < 3; i++) begin
			if (near_d[i] > tmin) tmin = near_d[i];
			if (far_d[i] < tmax) tmax = far_d[i];
		end
		hit_c = (miss == '0) && (tmax >= tmin) && !tmax[DW-1];
	end

	logic hit_s4, last_s4;
	logic [rbst_pkg::DIST_W-1:0] dist_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= hit_c;
			dist_s4 <= hit_c ? tmin[rbst_pkg::DIST_W-1:0] : '0;
			last_s4 <= last_q[NST-2];
		end
	end

	assign res.valid = vld_q[NST-1];
	assign res.hit = hit_s4;
	assign res.entry_distance = dist_s4;
	assign res.last_result = last_s4;

	a_miss_no_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |-> res.entry_distance == '0)
		else $error("miss carries a distance");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.entry_distance))
		else $error("stalled result changed");
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_busy |-> !box.ready)
		else $error("box taken during reciprocal update");
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for the ray box slab test block: directed and random boxes checked
// against an internal slab predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [rbst_pkg::PADDR_W-1:0] paddr;
	logic [rbst_pkg::PDATA_W-1:0] pwdata;
	logic [rbst_pkg::PDATA_W-1:0] prdata;
	logic pready;

	rbst_box_if box_ch ();
	rbst_res_if res_ch ();

	ray_box_slab_test dut (
		.clk(clk), .arst_n(arst_n), .box(box_ch.sink), .res(res_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// one expected result
	typedef struct {
		logic hit;
		logic [rbst_pkg::DIST_W-1:0] entry;
		logic last;
	} slab_result_t;

	// one box
	typedef struct {
		logic signed [rbst_pkg::COORD_W-1:0] lo [3];
		logic signed [rbst_pkg::COORD_W-1:0] hi [3];
		logic last;
	} box_t;

	// predictor copy of the ray registers
	logic signed [rbst_pkg::COORD_W-1:0] ray_origin [3];
	logic signed [rbst_pkg::DIR_W-1:0] ray_dir [3];
	logic [rbst_pkg::THR_W-1:0] ray_thr;

	slab_result_t hit_queue [$];
	int mismatches;
	int boxes_sent;
	int results_seen;
	int hits_seen;
	int idle_cycles;
	int res_wait;
	bit res_acc;
	logic hold_res;
	bit res_random_stall;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: cycles with no accepted transaction on either side
	always @(posedge clk) begin
		if ((box_ch.valid && box_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("watchdog: no progress for %0d cycles", idle_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// slab distance: sign * floor(|delta| * recip / 2^32), saturated
	function automatic longint slab_distance(input int ax, input longint delta);
		longint unsigned mag_d, recip, q;
		logic [127:0] prod;
		longint dmag;
		bit neg;
		dmag = ray_dir[ax] < 0 ? -longint'(ray_dir[ax]) : longint'(ray_dir[ax]);
		recip = (64'd1 << 48) / longint'(dmag);
		neg = (delta < 0) != (ray_dir[ax] < 0);
		mag_d = delta < 0 ? -delta : delta;
		prod = 128'(mag_d) * 128'(recip);
		q = prod[95:32];
		if (prod[127:96] != 0 || q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic slab_result_t predict_hit(input box_t b);
		slab_result_t r;
		longint tnear, tfar, lo, hi, o, a, c, dmag;
		bit miss;
		tnear = 0;
		tfar = 64'h7FFF_FFFF;
		miss = 0;
		for (int i = 0; i < 3; i++) begin
			lo = b.lo[i];
			hi = b.hi[i];
			o = ray_origin[i];
			dmag = ray_dir[i] < 0 ? -longint'(ray_dir[i]) : longint'(ray_dir[i]);
			// parallel axis: only an inside/outside slab test
			if (dmag <= longint'(ray_thr)) begin
				if (o < lo || o > hi)
					miss = 1;
			end else begin
				a = slab_distance(i, lo - o);
				c = slab_distance(i, hi - o);
				if ((a < c ? a : c) > tnear)
					tnear = a < c ? a : c;
				if ((a < c ? c : a) < tfar)
					tfar = a < c ? c : a;
			end
		end
		r.hit = !miss && tfar >= tnear && tfar >= 0;
		r.entry = r.hit ? tnear[rbst_pkg::DIST_W-1:0] : '0;
		r.last = b.last;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	// apb write: setup then access, pready always high
	task automatic write_reg(input rbst_pkg::reg_idx_t idx,
		input logic [rbst_pkg::PDATA_W-1:0] val);
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = rbst_pkg::PADDR_W'(idx) << 2;
		pwdata = val;
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		case (idx)
			rbst_pkg::REG_ORIGIN_X, rbst_pkg::REG_ORIGIN_Y, rbst_pkg::REG_ORIGIN_Z:
				ray_origin[int'(idx)] = val;
			rbst_pkg::REG_DIR_X, rbst_pkg::REG_DIR_Y, rbst_pkg::REG_DIR_Z:
				ray_dir[int'(idx) - int'(rbst_pkg::REG_DIR_X)] = val[rbst_pkg::DIR_W-1:0];
			rbst_pkg::REG_THRESHOLD: ray_thr = val[rbst_pkg::THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_ray(input int ox, oy, oz, input int dx, dy, dz, input int thr);
		write_reg(rbst_pkg::REG_ORIGIN_X, ox);
		write_reg(rbst_pkg::REG_ORIGIN_Y, oy);
		write_reg(rbst_pkg::REG_ORIGIN_Z, oz);
		write_reg(rbst_pkg::REG_DIR_X, dx);
		write_reg(rbst_pkg::REG_DIR_Y, dy);
		write_reg(rbst_pkg::REG_DIR_Z, dz);
		write_reg(rbst_pkg::REG_THRESHOLD, thr);
	endtask

	// send one box, after a random gap unless no_gap is set; predict at the accepting edge
	task automatic send_box(input box_t b, input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0);
		if (gap > 0) begin
			box_ch.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		box_ch.valid <= 1;
		box_ch.box_min_x <= b.lo[0];
		box_ch.box_min_y <= b.lo[1];
		box_ch.box_min_z <= b.lo[2];
		box_ch.box_max_x <= b.hi[0];
		box_ch.box_max_y <= b.hi[1];
		box_ch.box_max_z <= b.hi[2];
		box_ch.last_box <= b.last;
		do @(posedge clk); while (!box_ch.ready);
		hit_queue.push_back(predict_hit(b));
		boxes_sent++;
		@(negedge clk);
	endtask

	task automatic end_boxes();
		box_ch.valid <= 0;
	endtask

	// wait for the pipeline to drain before the next register write
	task automatic drain();
		end_boxes();
		while (hit_queue.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 40 << 16))) - (20 << 16);
		endcase
	endfunction

	function automatic logic [31:0] rand_dir();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32'h1_0000;
			2: return -32'sd65536;
			3: return $urandom_range(1, 4);
			4: return 32'($signed({$urandom} % 131072)) - 65536;
			default: return {14'b0, 18'($urandom)};
		endcase
	endfunction

	// a box around a random point, mostly well formed so slabs overlap
	function automatic box_t rand_box();
		box_t b;
		logic signed [31:0] c, w;
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				b.lo[i] = rand_coord();
				b.hi[i] = rand_coord();
			end else begin
				c = rand_coord();
				w = $urandom_range(0, 8 << 16);
				b.lo[i] = c - w;
				b.hi[i] = c + w;
				if (b.hi[i] < b.lo[i])
					b.hi[i] = 32'h7FFF_FFFF;
			end
		end
		b.last = $urandom_range(0, 1);
		return b;
	endfunction

	function automatic box_t make_box(input int lx, ly, lz, hx, hy, hz, input bit last);
		box_t b;
		b.lo[0] = lx; b.lo[1] = ly; b.lo[2] = lz;
		b.hi[0] = hx; b.hi[1] = hy; b.hi[2] = hz;
		b.last = last;
		return b;
	endfunction

	// result side: a random wait drawn per result when random stalls are on, long hold when asked
	always @(negedge clk) begin
		int w;
		w = res_wait;
		if (res_acc && res_random_stall)
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
		if (!arst_n || hold_res) begin
			res_ch.ready <= 0;
		end else if (w > 0) begin
			res_ch.ready <= 0;
			w--;
		end else begin
			res_ch.ready <= 1;
		end
		res_wait <= w;
	end

	// result checker
	always @(posedge clk) begin
		slab_result_t want;
		res_acc = arst_n && res_ch.valid && res_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (hit_queue.size() == 0) begin
				report_mismatch("unexpected result", res_ch.hit, -1);
			end else begin
				want = hit_queue.pop_front();
				if (res_ch.hit !== want.hit)
					report_mismatch("hit", res_ch.hit, want.hit);
				if (res_ch.entry_distance !== want.entry)
					report_mismatch("entry_distance", res_ch.entry_distance, want.entry);
				if (res_ch.last_result !== want.last)
					report_mismatch("last_result", res_ch.last_result, want.last);
				if (want.hit)
					hits_seen++;
			end
		end
	end

	// directed: reset ray along +x, corner and special cases
	task automatic test_directed();
		int one;
		one = 1 << 16;
		// box ahead, behind, straddling origin, all parallel miss on y/z
		send_box(make_box(5*one, -one, -one, 6*one, one, one, 0));
		send_box(make_box(-6*one, -one, -one, -5*one, one, one, 0));
		send_box(make_box(-one, -one, -one, one, one, one, 1));
		send_box(make_box(one, 2*one, -one, 2*one, 3*one, one, 0));
		// inverted box on parallel and non-parallel axes
		send_box(make_box(2*one, one, -one, one, -one, one, 0));
		send_box(make_box(2*one, -one, -one, one, one, one, 1));
		// extreme corners
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
		send_box(make_box(32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
		send_box(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1));
		drain();
		// tiny direction gives huge distances that saturate
		set_ray(32'h8000_0000, 0, 32'h7FFF_FFFF, 1, -1, 32'h1_0000, 0);
		send_box(make_box(32'h7FFF_FFFF, -one, 0, 32'h7FFF_FFFF, one, 32'h7FFF_FFFF, 0));
		send_box(make_box(0, 32'h8000_0000, 32'h8000_0000, one, 32'h7FFF_FFFF, 0, 1));
		drain();
		// direction beyond one: no axis parallel, then under maximum threshold x and z parallel, y not
		set_ray(one, one, one, 32'h1_FFFF, 32'h2_0000, 32'h2_0001, 32'h1_0000);
		send_box(make_box(0, 0, 0, 2*one, 2*one, 2*one, 1));
		send_box(make_box(0, 0, 0, 2*one, 2*one, 2*one, 0));
		drain();
		write_reg(rbst_pkg::REG_THRESHOLD, 32'h1_FFFF);
		send_box(make_box(0, 0, 0, 2*one, 2*one, 2*one, 1));
		send_box(make_box(0, 0, 3*one, 2*one, 2*one, 4*one, 0));
		drain();
	endtask

	// random rays, random boxes, several settings
	task automatic test_random(input int phases, input int per_phase);
		for (int p = 0; p < phases; p++) begin
			set_ray(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
				rand_dir(), $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
				: $urandom_range(0, 64));
			// every third phase sends its boxes back to back
			for (int k = 0; k < per_phase; k++)
				send_box(rand_box(), p % 3 == 0);
			drain();
		end
	endtask

	// receiver holds off while the sender keeps offering boxes
	task automatic test_backpressure();
		set_ray(0, 0, 0, 32'h0_B505, 32'h0_B505, 0, 16);
		fork
			begin
				hold_res = 1;
				repeat (200) @(negedge clk);
				hold_res = 0;
			end
			for (int k = 0; k < 40; k++)
				send_box(rand_box(), 1);
		join
		drain();
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		box_ch.valid = 0;
		box_ch.box_min_x = 0;
		box_ch.box_min_y = 0;
		box_ch.box_min_z = 0;
		box_ch.box_max_x = 0;
		box_ch.box_max_y = 0;
		box_ch.box_max_z = 0;
		box_ch.last_box = 0;
		res_ch.ready = 0;
		hold_res = 0;
		res_random_stall = 0;
		mismatches = 0;
		boxes_sent = 0;
		results_seen = 0;
		hits_seen = 0;
		idle_cycles = 0;
		// predictor reset state
		ray_origin[0] = 0; ray_origin[1] = 0; ray_origin[2] = 0;
		ray_dir[0] = 18'sd65536; ray_dir[1] = 0; ray_dir[2] = 0;
		ray_thr = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed();
		res_random_stall = 1;
		test_random(12, 38);
		test_backpressure();
		res_random_stall = 0;
		test_random(2, 20);

		drain();
		$display("covered %0d boxes, %0d results, %0d hits, with stalls and backpressure",
			boxes_sent, results_seen, hits_seen);
		if (mismatches == 0 && hit_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
design/rbst_pkg.sv
design/rbst_if.sv
design/rbst_recip.sv
design/rbst_cfg.sv
design/rbst_axis.sv
design/ray_box_slab_test.sv
dv/tb_top.sv
